// ===== hdl/lljd_pkg.sv =====
// Shared types and codes for the least-loaded job dispatcher.
package lljd_pkg;

	localparam int DEPTH_W = 5;

	localparam logic [1:0] MODE_ENQ   = 2'd0;
	localparam logic [1:0] MODE_DRAIN = 2'd1;
	localparam logic [1:0] MODE_DEPTH = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_BADFN = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_EMPTY = 2'd3;

	localparam logic [1:0] CFG_CORE_COUNT  = 2'd0;
	localparam logic [1:0] CFG_WORKER_MASK = 2'd1;
	localparam logic [1:0] CFG_FALLBACK    = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  core;
		logic [15:0] handler;
		logic [63:0] job;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [2:0]         target_core;
		logic [15:0]        handler_out;
		logic [63:0]        job_out;
		logic [DEPTH_W-1:0] depth;
		logic               last;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic skip;
		logic drain_go;
		logic pop_last;
	} sts_t;

endpackage

// ===== hdl/least_loaded_job_dispatcher.sv =====
// Top level of the least-loaded job dispatcher with one bounded job queue per core.
// An item is taken in S_IDLE and executed in S_EXEC once the result register is free.
// In S_DRAIN the job memory read port delivers one job per cycle while the result register is free.
// The result register lets a new item be accepted while the last result beat still waits.
// Reset clears queue pointers, counts and the result valid; job memory contents are not cleared.
module least_loaded_job_dispatcher
	import lljd_pkg::*;
#(
	parameter int NUM_CORES    = 8,
	parameter int QUEUE_DEPTH  = 16,
	parameter int HANDLER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [7:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	lljd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lljd_datapath #(
		.NUM_CORES    (NUM_CORES),
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLER_BITS (HANDLER_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/lljd_ctrl.sv =====
// Control state machine of the least-loaded job dispatcher.
module lljd_ctrl
	import lljd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  sts_t  sts,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.skip) begin
					state_nxt = S_IDLE;
				end else if (sts.slot_free) begin
					cmd.exec  = 1'b1;
					state_nxt = sts.drain_go ? S_DRAIN : S_IDLE;
				end
			end
			S_DRAIN: begin
				if (sts.slot_free) begin
					cmd.pop = 1'b1;
					if (sts.pop_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/lljd_datapath.sv =====
// Datapath of the dispatcher: configuration, queue pointers, job memory and result register.
module lljd_datapath
	import lljd_pkg::*;
#(
	parameter int NUM_CORES    = 8,
	parameter int QUEUE_DEPTH  = 16,
	parameter int HANDLER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      in_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [7:0] cfg_data,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data
);

	localparam int NC        = (NUM_CORES < 8) ? NUM_CORES : 8;
	localparam int CW        = (NC > 1) ? $clog2(NC) : 1;
	localparam int PW        = $clog2(QUEUE_DEPTH);
	localparam int CNTW      = $clog2(QUEUE_DEPTH + 1);
	localparam int HW        = (HANDLER_BITS < 16) ? HANDLER_BITS : 16;
	localparam int ENTRY_W   = HW + 64;
	localparam int MEM_DEPTH = 2 ** (CW + PW);

	localparam logic [CNTW-1:0] QD_CNT   = CNTW'(QUEUE_DEPTH);
	localparam logic [PW-1:0]   PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [4:0]      CORE_LIM = 5'(NUM_CORES);

	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	logic [3:0] core_count_q;
	logic [7:0] worker_mask_q;
	logic [2:0] fallback_q;

	item_t item_q;

	logic [PW-1:0]   rp_q  [NC];
	logic [PW-1:0]   wp_q  [NC];
	logic [CNTW-1:0] cnt_q [NC];

	logic [ENTRY_W-1:0] mem [MEM_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic            out_valid_q;
	result_t         out_q;

	logic [4:0]      live_n;
	logic            core_ok;
	logic [CW-1:0]   rd_core;
	logic [CNTW-1:0] cnt_rd;
	logic [PW-1:0]   rp_sel;
	logic [CW+PW-1:0] rd_addr;

	logic            found;
	logic [CW-1:0]   best_i;
	logic [CNTW-1:0] best_d;
	logic [2:0]      best_core;
	logic [CW-1:0]   wr_idx;
	logic [CNTW-1:0] best_cnt;
	logic            target_ok;

	result_t         exec_res;
	logic            has_res;
	logic            enq_wr;
	logic            drain_go;
	logic            wr_en;
	logic            load_out;
	logic            slot_free;
	result_t         pop_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_count_q  <= 4'd8;
			worker_mask_q <= 8'hFF;
			fallback_q    <= 3'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_CORE_COUNT:  core_count_q  <= cfg_data[3:0];
				CFG_WORKER_MASK: worker_mask_q <= cfg_data;
				CFG_FALLBACK:    fallback_q    <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	assign live_n  = ({1'b0, core_count_q} > CORE_LIM) ? CORE_LIM : {1'b0, core_count_q};
	assign core_ok = {2'b00, item_q.core} < live_n;
	assign rd_core = CW'(item_q.core);
	assign cnt_rd  = cnt_q[rd_core];
	assign rp_sel  = cmd.pop ? wrap_next(rp_q[rd_core]) : rp_q[rd_core];
	assign rd_addr = {rd_core, rp_sel};

	always_comb begin
		found  = 1'b0;
		best_i = '0;
		best_d = '0;
		for (int i = 0; i < NC; i++) begin
			if ((5'(i) < live_n) && worker_mask_q[i] && (!found || (cnt_q[i] < best_d))) begin
				found  = 1'b1;
				best_i = CW'(i);
				best_d = cnt_q[i];
			end
		end
	end

	assign best_core = found ? 3'(best_i) : fallback_q;
	assign wr_idx    = found ? best_i : CW'(fallback_q);
	assign best_cnt  = found ? best_d : cnt_q[CW'(fallback_q)];
	assign target_ok = {2'b00, best_core} < live_n;

	always_comb begin
		exec_res      = '0;
		exec_res.last = 1'b1;
		has_res       = 1'b1;
		enq_wr        = 1'b0;
		drain_go      = 1'b0;
		unique case (item_q.mode)
			MODE_ENQ: begin
				if (item_q.handler == 16'd0) begin
					exec_res.status = STATUS_BADFN;
				end else if (!target_ok) begin
					exec_res.status      = STATUS_EMPTY;
					exec_res.target_core = best_core;
				end else if (best_cnt == QD_CNT) begin
					exec_res.status      = STATUS_FULL;
					exec_res.target_core = best_core;
					exec_res.depth       = DEPTH_W'(best_cnt);
				end else begin
					exec_res.status      = STATUS_OK;
					exec_res.target_core = best_core;
					exec_res.depth       = DEPTH_W'(best_cnt + CNTW'(1));
					enq_wr               = 1'b1;
				end
			end
			MODE_DRAIN: begin
				exec_res.target_core = item_q.core;
				exec_res.status      = STATUS_EMPTY;
				if (core_ok && (cnt_rd != '0)) begin
					drain_go = 1'b1;
					has_res  = 1'b0;
				end
			end
			MODE_DEPTH: begin
				exec_res.target_core = item_q.core;
				if (core_ok) begin
					exec_res.status = STATUS_OK;
					exec_res.depth  = DEPTH_W'(cnt_rd);
				end else begin
					exec_res.status = STATUS_EMPTY;
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	always_comb begin
		pop_res             = '0;
		pop_res.status      = STATUS_OK;
		pop_res.target_core = item_q.core;
		pop_res.handler_out = 16'(rd_q[ENTRY_W-1:64]);
		pop_res.job_out     = rd_q[63:0];
		pop_res.depth       = DEPTH_W'(cnt_rd - CNTW'(1));
		pop_res.last        = (cnt_rd == CNTW'(1));
	end

	assign wr_en     = cmd.exec && enq_wr;
	assign load_out  = (cmd.exec && has_res) || cmd.pop;
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				rp_q[i]  <= '0;
				wp_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (wr_en) begin
				wp_q[wr_idx]  <= wrap_next(wp_q[wr_idx]);
				cnt_q[wr_idx] <= best_cnt + CNTW'(1);
			end
			if (cmd.pop) begin
				rp_q[rd_core]  <= rp_sel;
				cnt_q[rd_core] <= cnt_rd - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{wr_idx, wp_q[wr_idx]}] <= {item_q.handler[HW-1:0], item_q.job};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= cmd.pop ? pop_res : exec_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.slot_free = slot_free;
	assign sts.skip      = !has_res && !drain_go;
	assign sts.drain_go  = drain_go;
	assign sts.pop_last  = (cnt_rd == CNTW'(1));

	// A new result is loaded only when the previous one has left or leaves now.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> slot_free)
		else $error("result register overwritten before its beat was taken");

	// A drain pop never runs past the pending jobs of its core.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cnt_rd != '0))
		else $error("pop from an empty core queue");

	// An enqueue never writes into a full queue.
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (best_cnt != QD_CNT))
		else $error("job written into a full core queue");

endmodule
